### hw/rtl/pcrl_pkg.sv
// Package for the per-client rate limiter: table geometry, entry layout,
// action codes and configuration register indexes.
// No dependencies.
package pcrl_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = IdxW + 1;

  localparam logic [1:0] ActRequest    = 2'd0;
  localparam logic [1:0] ActConnect    = 2'd1;
  localparam logic [1:0] ActDisconnect = 2'd2;

  localparam logic [1:0] RegMaxConn  = 2'd0;
  localparam logic [1:0] RegMaxReq   = 2'd1;
  localparam logic [1:0] RegWindow   = 2'd2;

  localparam logic [7:0]  MaxConnReset = 8'd16;
  localparam logic [15:0] MaxReqReset  = 16'd600;
  localparam logic [15:0] WindowReset  = 16'd60;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  connections;
    logic [15:0] requests;
    logic [31:0] window_start;
  } entry_t;

endpackage

### hw/rtl/per_client_rate_limiter_top.sv
// Per-client rate limiter: client table, sequential scan and update.
// Depends on pcrl_pkg.
//
// Usage:
//   Each input transfer (in_valid_i high, in_stall_o low) carries a client
//   address, an action (request, connect, disconnect) and the current second.
//   The block answers every transfer with exactly one output transfer holding
//   granted_o; it is held while out_stall_i is high.
//   The table lives in a memory with one read and one write port, read one
//   entry per cycle. A transfer that matches entry k ends the scan at that
//   entry; one without a match scans all TableEntries entries (256). The
//   scan of the table sets how long an item takes. in_stall_o stays high
//   while an item is at work, so no new item is taken before its result is
//   ready, and the final update waits while an earlier result is still
//   stalled at the output register.
//   Reset clears all used marks and loads the register defaults (16
//   connections, 600 requests, 60 second window); no clearing pass is needed.
//   Configuration registers sit on the APB port at byte addresses 0, 4 and 8
//   and should be written only while the block is idle.
module per_client_rate_limiter_top
  import pcrl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] client_address_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] now_seconds_i,
  // Output channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        granted_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StApply = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers.
  logic [7:0]  max_conn_q;
  logic [15:0] max_req_q;
  logic [15:0] window_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_conn_q <= MaxConnReset;
      max_req_q  <= MaxReqReset;
      window_q   <= WindowReset;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegMaxConn: max_conn_q <= pwdata[7:0];
        RegMaxReq:  max_req_q  <= pwdata[15:0];
        RegWindow:  window_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMaxConn: prdata = {24'd0, max_conn_q};
      RegMaxReq:  prdata = {16'd0, max_req_q};
      RegWindow:  prdata = {16'd0, window_q};
      default:    prdata = 32'd0;
    endcase
  end

  // Captured input item.
  logic [31:0] addr_q;
  logic [1:0]  action_q;
  logic [31:0] now_q;
  logic        in_acc;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      addr_q   <= client_address_i;
      action_q <= action_i;
      now_q    <= now_seconds_i;
    end
  end

  // Table storage: used marks in flops, entry payload in memory.
  logic [TableEntries-1:0] used_q;
  entry_t                  mem [TableEntries];
  entry_t                  mem_rd_q;
  logic                    used_rd_q;
  logic [CntW-1:0]         rd_cnt_q;
  logic [IdxW-1:0]         rd_idx;
  logic                    rd_more;
  logic                    ev_vld_q;
  logic [IdxW-1:0]         ev_idx_q;

  assign rd_idx  = rd_cnt_q[IdxW-1:0];
  assign rd_more = (rd_cnt_q < CntW'(TableEntries));

  always_ff @(posedge clk_i) begin
    mem_rd_q  <= mem[rd_idx];
    used_rd_q <= used_q[rd_idx];
    ev_idx_q  <= rd_idx;
  end

  // Evaluation of the entry read in the previous cycle.
  logic [31:0] age;
  logic        ev_expired;
  logic        ev_hit;
  logic        ev_spare;
  logic        ev_last;

  assign age        = now_q - mem_rd_q.window_start;
  assign ev_expired = (age >= {16'd0, window_q});
  assign ev_hit     = ev_vld_q & used_rd_q & (mem_rd_q.address == addr_q);
  assign ev_spare   = ev_vld_q & (~used_rd_q |
                                  ((mem_rd_q.connections == 8'd0) & ev_expired));
  assign ev_last    = (ev_idx_q == IdxW'(TableEntries - 1));

  logic            hit_q;
  logic [IdxW-1:0] hit_idx_q;
  entry_t          hit_ent_q;
  logic            hit_exp_q;
  logic            spare_vld_q;
  logic [IdxW-1:0] spare_idx_q;

  // Output register.
  logic out_vld_q;
  logic granted_q;
  logic emit;

  assign emit = (state_q == StApply) & (~out_vld_q | ~out_stall_i);

  // Update of the matched or claimed entry.
  logic            claim;
  logic            take;
  entry_t          upd;
  logic            upd_exp;
  logic            grant;
  logic [IdxW-1:0] wr_idx;

  assign claim  = ~hit_q & spare_vld_q & (action_q == ActConnect);
  assign take   = hit_q | claim;
  assign wr_idx = hit_q ? hit_idx_q : spare_idx_q;

  always_comb begin
    if (hit_q) begin
      upd     = hit_ent_q;
      upd_exp = hit_exp_q;
    end else begin
      upd.address      = addr_q;
      upd.connections  = 8'd0;
      upd.requests     = 16'd0;
      upd.window_start = now_q;
      upd_exp          = (window_q == 16'd0);
    end
    if (upd_exp) begin
      upd.requests     = 16'd0;
      upd.window_start = now_q;
    end
    grant = 1'b0;
    case (action_q)
      ActDisconnect: begin
        if (upd.connections != 8'd0) begin
          upd.connections = upd.connections - 8'd1;
        end
        grant = 1'b1;
      end
      ActConnect: begin
        if (upd.connections < max_conn_q) begin
          upd.connections = upd.connections + 8'd1;
          grant = 1'b1;
        end
      end
      ActRequest: begin
        if (upd.requests < max_req_q) begin
          upd.requests = upd.requests + 16'd1;
          grant = 1'b1;
        end
      end
      default: grant = 1'b0;
    endcase
    grant = grant & take;
  end

  always_ff @(posedge clk_i) begin
    if (emit && take) begin
      mem[wr_idx] <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (emit && claim) begin
      used_q[wr_idx] <= 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (ev_hit || (ev_vld_q && ev_last)) begin
          state_d = StApply;
        end
      end
      StApply: begin
        if (emit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_cnt_q    <= '0;
      ev_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      spare_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        rd_cnt_q    <= '0;
        ev_vld_q    <= 1'b0;
        hit_q       <= 1'b0;
        spare_vld_q <= 1'b0;
      end else if (state_q == StScan) begin
        ev_vld_q <= rd_more & ~ev_hit;
        if (rd_more) begin
          rd_cnt_q <= rd_cnt_q + CntW'(1);
        end
        if (ev_hit) begin
          hit_q <= 1'b1;
        end else if (ev_spare) begin
          spare_vld_q <= 1'b1;
        end
      end else begin
        ev_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StScan) begin
      if (ev_hit) begin
        hit_idx_q <= ev_idx_q;
        hit_ent_q <= mem_rd_q;
        hit_exp_q <= ev_expired;
      end else if (ev_spare) begin
        // The last free or idle-expired entry before the match wins.
        spare_idx_q <= ev_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      granted_q <= grant;
    end
  end

  assign out_valid_o = out_vld_q;
  assign granted_o   = granted_q;

`ifndef SYNTHESIS
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (rd_cnt_q <= CntW'(TableEntries)))
    else $error("scan counter ran past the table");

  a_used_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (($past(used_q) & ~used_q) == '0))
    else $error("a used mark was cleared");

  a_result_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit |=> out_vld_q && (state_q == StIdle)))
    else $error("result not presented after the update");
`endif

endmodule
